// ----- rtl/salc_pkg.sv -----
// ---------------------------------------------------------------------------
// salc_pkg
// shared types and constants of the size-aware object cache
// ---------------------------------------------------------------------------
package salc_pkg;

  localparam int unsigned EntriesDefault = 1024;

  localparam int unsigned KeyW   = 32;
  localparam int unsigned SizeW  = 32;
  localparam int unsigned CapW   = 41;
  localparam int unsigned ThrW   = 33;
  localparam int unsigned EvcW   = 11;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgW   = 41;
  localparam int unsigned InDataW  = 64;
  localparam int unsigned OutDataW = 56;
  localparam int unsigned EntryW = KeyW + SizeW;

  localparam logic [CapW-1:0] CapReset = CapW'(64'd1073741824);
  localparam logic [ThrW-1:0] ThrReset = ThrW'(64'd4294967296);
  localparam logic [EvcW-1:0] EvcMax   = '1;

  localparam logic [CfgIdxW-1:0] RegCapacity  = 2'd0;
  localparam logic [CfgIdxW-1:0] RegFifoMode  = 2'd1;
  localparam logic [CfgIdxW-1:0] RegThreshold = 2'd2;

  // datapath operations issued by the controller
  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_SRCH_RD,
    OP_SRCH_CMP,
    OP_DROP,
    OP_SD_RD,
    OP_SD_WR,
    OP_EV_RD,
    OP_EV_UPD,
    OP_HIT,
    OP_SU_START,
    OP_SU_RD,
    OP_SU_WR,
    OP_INS_WR,
    OP_FINISH
  } op_e;

  typedef struct packed {
    op_e op;
  } cmd_t;

  typedef struct packed {
    logic idx_eq_cnt;
    logic match;
    logic found;
    logic action;
    logic size_eq;
    logic fifo;
    logic pos_zero;
    logic admit_ok;
    logic need_evict;
    logic sd_done;
    logic idx_zero;
    logic out_free;
  } stat_t;

endpackage

// ----- rtl/salc_ram.sv -----
// ---------------------------------------------------------------------------
// salc_ram
// generic single write, single read ram with registered read data
// ---------------------------------------------------------------------------
module salc_ram #(
  parameter int unsigned Width = 64,
  parameter int unsigned Depth = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/salc_datapath.sv -----
// ---------------------------------------------------------------------------
// salc_datapath
// entry store in recency order, configuration, byte and entry counters, result register
// ---------------------------------------------------------------------------
module salc_datapath #(
  parameter int unsigned Entries = salc_pkg::EntriesDefault
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  salc_pkg::cmd_t                     cmd_i,
  output salc_pkg::stat_t                    stat_o,
  input  logic                               cfg_we_i,
  input  logic [salc_pkg::CfgIdxW-1:0]       cfg_idx_i,
  input  logic [salc_pkg::CfgW-1:0]          cfg_data_i,
  input  logic                               in_action_i,
  input  logic [salc_pkg::KeyW-1:0]          in_key_i,
  input  logic [salc_pkg::SizeW-1:0]         in_size_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic [salc_pkg::OutDataW-1:0]      out_data_o
);

  localparam int unsigned AW = (Entries > 1) ? $clog2(Entries) : 1;
  localparam int unsigned CW = $clog2(Entries + 1);
  localparam logic [CW-1:0] CntFull = CW'(Entries);

  logic [salc_pkg::CapW-1:0]  cap_q;
  logic                       fifo_q;
  logic [salc_pkg::ThrW-1:0]  thr_q;

  logic                       action_q;
  logic [salc_pkg::KeyW-1:0]  key_q;
  logic [salc_pkg::SizeW-1:0] size_q;
  logic [salc_pkg::SizeW-1:0] fsize_q;
  logic [CW-1:0]              idx_q, cnt_q, pos_q;
  logic                       found_q, hit_q, adm_q, mis_q;
  logic [salc_pkg::EvcW-1:0]  evc_q;
  logic [salc_pkg::CapW-1:0]  bytes_q;
  logic                       out_valid_q;
  logic [salc_pkg::OutDataW-1:0] out_data_q;

  logic                       ram_we;
  logic [AW-1:0]              ram_waddr, ram_raddr;
  logic [salc_pkg::EntryW-1:0] ram_wdata, ram_rdata;
  logic [salc_pkg::KeyW-1:0]  rd_key;
  logic [salc_pkg::SizeW-1:0] rd_size;
  logic [salc_pkg::CapW:0]    need_bytes;
  logic [salc_pkg::EvcW-1:0]  evc_inc;

  assign rd_key  = ram_rdata[salc_pkg::EntryW-1 -: salc_pkg::KeyW];
  assign rd_size = ram_rdata[salc_pkg::SizeW-1:0];
  assign need_bytes = {1'b0, bytes_q} + (salc_pkg::CapW+1)'(size_q);
  assign evc_inc = (evc_q == salc_pkg::EvcMax) ? evc_q : evc_q + 1'b1;

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = idx_q[AW-1:0];
    ram_wdata = ram_rdata;
    ram_raddr = idx_q[AW-1:0];
    unique case (cmd_i.op)
      salc_pkg::OP_SD_RD: ram_raddr = AW'(idx_q + 1'b1);
      salc_pkg::OP_EV_RD: ram_raddr = AW'(cnt_q - 1'b1);
      salc_pkg::OP_SU_RD: ram_raddr = AW'(idx_q - 1'b1);
      salc_pkg::OP_SD_WR, salc_pkg::OP_SU_WR: ram_we = 1'b1;
      salc_pkg::OP_INS_WR: begin
        ram_we    = 1'b1;
        ram_waddr = '0;
        ram_wdata = {key_q, size_q};
      end
      default: ;
    endcase
  end

  salc_ram #(
    .Width(salc_pkg::EntryW),
    .Depth(Entries)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  always_comb begin
    stat_o.idx_eq_cnt = (idx_q == cnt_q);
    stat_o.match      = (rd_key == key_q);
    stat_o.found      = found_q;
    stat_o.action     = action_q;
    stat_o.size_eq    = (fsize_q == size_q);
    stat_o.fifo       = fifo_q;
    stat_o.pos_zero   = (pos_q == '0);
    stat_o.admit_ok   = ((salc_pkg::CapW)'(size_q) < cap_q) &&
                        ((salc_pkg::ThrW)'(size_q) < thr_q);
    stat_o.need_evict = (cnt_q != '0) &&
                        ((need_bytes > {1'b0, cap_q}) || (cnt_q == CntFull));
    stat_o.sd_done    = (idx_q >= cnt_q);
    stat_o.idx_zero   = (idx_q == '0);
    stat_o.out_free   = !out_valid_q || out_ready_i;
  end

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q  <= salc_pkg::CapReset;
      fifo_q <= 1'b0;
      thr_q  <= salc_pkg::ThrReset;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        salc_pkg::RegCapacity:  cap_q  <= cfg_data_i;
        salc_pkg::RegFifoMode:  fifo_q <= cfg_data_i[0];
        salc_pkg::RegThreshold: thr_q  <= cfg_data_i[salc_pkg::ThrW-1:0];
        default: ;
      endcase
    end
  end

  // payload of the item in work, the position and size of its found entry, and the result data
  always_ff @(posedge clk_i) begin
    if (cmd_i.op == salc_pkg::OP_LOAD) begin
      action_q <= in_action_i;
      key_q    <= in_key_i;
      size_q   <= in_size_i;
    end
    if (cmd_i.op == salc_pkg::OP_SRCH_CMP && stat_o.match) begin
      pos_q   <= idx_q;
      fsize_q <= rd_size;
    end
    if (cmd_i.op == salc_pkg::OP_FINISH) begin
      out_data_q <= {1'b0, bytes_q, evc_q, mis_q, adm_q, hit_q};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q       <= '0;
      cnt_q       <= '0;
      bytes_q     <= '0;
      found_q     <= 1'b0;
      hit_q       <= 1'b0;
      adm_q       <= 1'b0;
      mis_q       <= 1'b0;
      evc_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      // a new result replaces the one leaving in the same cycle
      if (out_valid_q && out_ready_i && cmd_i.op != salc_pkg::OP_FINISH) begin
        out_valid_q <= 1'b0;
      end
      unique case (cmd_i.op)
        salc_pkg::OP_LOAD: begin
          idx_q   <= '0;
          found_q <= 1'b0;
          hit_q   <= 1'b0;
          adm_q   <= 1'b0;
          mis_q   <= 1'b0;
          evc_q   <= '0;
        end
        salc_pkg::OP_SRCH_CMP: begin
          if (stat_o.match) begin
            found_q <= 1'b1;
          end else begin
            idx_q <= idx_q + 1'b1;
          end
        end
        salc_pkg::OP_DROP: begin
          bytes_q <= bytes_q - (salc_pkg::CapW)'(fsize_q);
          cnt_q   <= cnt_q - 1'b1;
          idx_q   <= pos_q;
          evc_q   <= evc_inc;
          mis_q   <= !action_q;
        end
        salc_pkg::OP_SD_WR: idx_q <= idx_q + 1'b1;
        salc_pkg::OP_EV_UPD: begin
          bytes_q <= bytes_q - (salc_pkg::CapW)'(rd_size);
          cnt_q   <= cnt_q - 1'b1;
          evc_q   <= evc_inc;
        end
        salc_pkg::OP_HIT: begin
          hit_q <= 1'b1;
          idx_q <= pos_q;
        end
        salc_pkg::OP_SU_START: idx_q <= cnt_q;
        salc_pkg::OP_SU_WR: idx_q <= idx_q - 1'b1;
        salc_pkg::OP_INS_WR: begin
          if (!hit_q) begin
            cnt_q   <= cnt_q + 1'b1;
            bytes_q <= bytes_q + (salc_pkg::CapW)'(size_q);
            adm_q   <= 1'b1;
          end
        end
        salc_pkg::OP_FINISH: out_valid_q <= 1'b1;
        default: ;
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

// ----- rtl/salc_ctrl.sv -----
// ---------------------------------------------------------------------------
// salc_ctrl
// sequencer: search, drop, tail eviction, lru promotion, front insertion
// ---------------------------------------------------------------------------
module salc_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  salc_pkg::stat_t stat_i,
  output salc_pkg::cmd_t  cmd_o
);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SRCH_RD,
    ST_SRCH_CMP,
    ST_DECIDE,
    ST_SD_RD,
    ST_SD_WR,
    ST_ADMIT,
    ST_EV_CHK,
    ST_EV_UPD,
    ST_SU_RD,
    ST_SU_WR,
    ST_INS_WR,
    ST_FIN
  } state_e;

  state_e state_q, state_d;

  assign in_ready_o = (state_q == ST_IDLE);

  always_comb begin
    state_d   = state_q;
    cmd_o.op  = salc_pkg::OP_NONE;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.op = salc_pkg::OP_LOAD;
          state_d  = ST_SRCH_RD;
        end
      end
      ST_SRCH_RD: begin
        if (stat_i.idx_eq_cnt) begin
          state_d = ST_DECIDE;
        end else begin
          cmd_o.op = salc_pkg::OP_SRCH_RD;
          state_d  = ST_SRCH_CMP;
        end
      end
      ST_SRCH_CMP: begin
        cmd_o.op = salc_pkg::OP_SRCH_CMP;
        state_d  = stat_i.match ? ST_DECIDE : ST_SRCH_RD;
      end
      ST_DECIDE: begin
        priority if (stat_i.action) begin
          if (stat_i.found) begin
            cmd_o.op = salc_pkg::OP_DROP;
            state_d  = ST_SD_RD;
          end else begin
            state_d = ST_FIN;
          end
        end else if (stat_i.found && stat_i.size_eq) begin
          cmd_o.op = salc_pkg::OP_HIT;
          state_d  = (stat_i.fifo || stat_i.pos_zero) ? ST_FIN : ST_SU_RD;
        end else if (stat_i.found) begin
          cmd_o.op = salc_pkg::OP_DROP;
          state_d  = ST_SD_RD;
        end else begin
          state_d = ST_ADMIT;
        end
      end
      ST_SD_RD: begin
        if (stat_i.sd_done) begin
          state_d = stat_i.action ? ST_FIN : ST_ADMIT;
        end else begin
          cmd_o.op = salc_pkg::OP_SD_RD;
          state_d  = ST_SD_WR;
        end
      end
      ST_SD_WR: begin
        cmd_o.op = salc_pkg::OP_SD_WR;
        state_d  = ST_SD_RD;
      end
      ST_ADMIT: state_d = stat_i.admit_ok ? ST_EV_CHK : ST_FIN;
      ST_EV_CHK: begin
        if (stat_i.need_evict) begin
          cmd_o.op = salc_pkg::OP_EV_RD;
          state_d  = ST_EV_UPD;
        end else begin
          cmd_o.op = salc_pkg::OP_SU_START;
          state_d  = ST_SU_RD;
        end
      end
      ST_EV_UPD: begin
        cmd_o.op = salc_pkg::OP_EV_UPD;
        state_d  = ST_EV_CHK;
      end
      ST_SU_RD: begin
        if (stat_i.idx_zero) begin
          state_d = ST_INS_WR;
        end else begin
          cmd_o.op = salc_pkg::OP_SU_RD;
          state_d  = ST_SU_WR;
        end
      end
      ST_SU_WR: begin
        cmd_o.op = salc_pkg::OP_SU_WR;
        state_d  = ST_SU_RD;
      end
      ST_INS_WR: begin
        cmd_o.op = salc_pkg::OP_INS_WR;
        state_d  = ST_FIN;
      end
      ST_FIN: begin
        if (stat_i.out_free) begin
          cmd_o.op = salc_pkg::OP_FINISH;
          state_d  = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ----- rtl/size_aware_lru_cache.sv -----
// ---------------------------------------------------------------------------
// size_aware_lru_cache
// byte-capacity object cache with lru or fifo replacement
// ---------------------------------------------------------------------------
// usage
//   s_axis carries one request or invalidate per transfer, m_axis returns
//   exactly one result per transfer, in order; cfg writes capacity, fifo
//   mode and admission threshold; the user must do so while idle (unchecked)
// storage and sequencing
//   entries are kept in a ram in recency order (front at address 0)
//   lookup scans the live entries from the front, reading and comparing
//   each in turn; dropping an entry at position p moves the entries behind
//   it forward; every tail eviction removes the last entry; an lru
//   promotion moves the entries ahead of it back, and insertion at the
//   front moves every live entry back; these steps share the single
//   ram port pair and run one after another, and one item is in work at a
//   time
// reset
//   cache empty, byte count zero, capacity 2^30, lru mode, limit off
// stall
//   a finished result waits in the output register; the next item is
//   accepted meanwhile and holds only at its own finish until m_axis drains
// ---------------------------------------------------------------------------
module size_aware_lru_cache #(
  parameter int unsigned Entries = salc_pkg::EntriesDefault
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // object_id [31:0], object_size [63:32]
  input  logic [salc_pkg::InDataW-1:0]  s_axis_tdata,
  // action [0]
  input  logic                          s_axis_tuser,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // hit [0], admitted [1], size_mismatch [2], evicted_count [13:3],
  // bytes_used [54:14], zero [55]
  output logic [salc_pkg::OutDataW-1:0] m_axis_tdata,
  input  logic                          cfg_we_i,
  input  logic [salc_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [salc_pkg::CfgW-1:0]     cfg_data_i
);

  salc_pkg::cmd_t  cmd;
  salc_pkg::stat_t stat;

  salc_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(s_axis_tvalid),
    .in_ready_o(s_axis_tready),
    .stat_i    (stat),
    .cmd_o     (cmd)
  );

  salc_datapath #(
    .Entries(Entries)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .stat_o     (stat),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_action_i(s_axis_tuser),
    .in_key_i   (s_axis_tdata[31:0]),
    .in_size_i  (s_axis_tdata[63:32]),
    .out_valid_o(m_axis_tvalid),
    .out_ready_i(m_axis_tready),
    .out_data_o (m_axis_tdata)
  );

endmodule

// ----- dv/testbench.sv -----
// ---------------------------------------------------------------------------
// testbench
// self-checking bench for the size-aware object cache: a behavioural copy of
// the cache predicts every result, which is matched against the m_axis output
// ---------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned Entries  = salc_pkg::EntriesDefault;
  localparam int unsigned KeyW     = salc_pkg::KeyW;
  localparam int unsigned SizeW    = salc_pkg::SizeW;
  localparam int unsigned CapW     = salc_pkg::CapW;
  localparam int unsigned ThrW     = salc_pkg::ThrW;
  localparam int unsigned EvcW     = salc_pkg::EvcW;
  localparam int unsigned CfgIdxW  = salc_pkg::CfgIdxW;
  localparam int unsigned CfgW     = salc_pkg::CfgW;
  localparam int unsigned InDataW  = salc_pkg::InDataW;
  localparam int unsigned OutDataW = salc_pkg::OutDataW;
  localparam logic [CfgIdxW-1:0] RegUnused = 2'd3;  // no register behind it
  localparam int unsigned CycleLimit = 20_000_000;
  localparam logic [CapW-1:0] CapMax = CapW'(64'd1099511627776);
  localparam logic [ThrW-1:0] ThrMax = ThrW'(64'd4294967296);
  localparam bit ActRequest = 1'b0;
  localparam bit ActInvalidate = 1'b1;

  typedef struct packed {
    logic            hit;
    logic            admitted;
    logic            mismatch;
    logic [EvcW-1:0] evicted;
    logic [CapW-1:0] bytes;
  } result_t;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [InDataW-1:0]  s_axis_tdata = '0;
  logic                s_axis_tuser = 1'b0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [OutDataW-1:0] m_axis_tdata;
  logic                cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx_i = '0;
  logic [CfgW-1:0]     cfg_data_i = '0;

  size_aware_lru_cache i_dut (.*);

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // shadow copy of the cache
  logic [KeyW-1:0]  cache_key   [Entries];
  logic [SizeW-1:0] cache_bytes [Entries];
  bit               cache_live  [Entries];
  int               cache_rank  [Entries];
  logic [CapW-1:0]  used_bytes;
  int               live_entries;
  logic [CapW-1:0]  capacity_r;
  bit               fifo_r;
  logic [ThrW-1:0]  threshold_r;

  result_t pending_results[$];
  int      errors = 0;
  int      cycles = 0;
  int      send_idle_pct = 0;
  int      recv_stall_pct = 0;

  task automatic report(input string what);
    $display("mismatch at cycle %0d: %s", cycles, what);
    errors++;
  endtask

  // remove one slot and close the gap in the recency order
  task automatic drop_entry(input int s);
    int rk;
    rk = cache_rank[s];
    for (int i = 0; i < Entries; i++) begin
      if (cache_live[i] && cache_rank[i] > rk) cache_rank[i]--;
    end
    cache_live[s] = 1'b0;
    used_bytes    = used_bytes - CapW'(cache_bytes[s]);
    live_entries--;
  endtask

  task automatic drop_tail();
    int victim;
    victim = -1;
    for (int i = 0; i < Entries; i++) begin
      if (victim < 0 && cache_live[i] && cache_rank[i] == live_entries - 1) victim = i;
    end
    if (victim >= 0) drop_entry(victim);
  endtask

  task automatic predict_access(input bit act, input logic [KeyW-1:0] id,
                                input logic [SizeW-1:0] sz, output result_t r);
    int found;
    int ev;
    int rk;
    int slot;
    r = '0;
    found = -1;
    ev = 0;
    for (int i = 0; i < Entries; i++) begin
      if (found < 0 && cache_live[i] && cache_key[i] == id) found = i;
    end
    if (act == ActInvalidate) begin
      if (found >= 0) begin
        drop_entry(found);
        ev = 1;
      end
    end else if (found >= 0 && cache_bytes[found] == sz) begin
      r.hit = 1'b1;
      if (!fifo_r) begin
        rk = cache_rank[found];
        for (int i = 0; i < Entries; i++) begin
          if (cache_live[i] && cache_rank[i] < rk) cache_rank[i]++;
        end
        cache_rank[found] = 0;
      end
    end else begin
      if (found >= 0) begin
        r.mismatch = 1'b1;
        drop_entry(found);
        ev = 1;
      end
      if (CapW'(sz) < capacity_r && ThrW'(sz) < threshold_r) begin
        // evict from the tail until the bytes fit and a slot is free
        while (live_entries > 0 &&
               (({1'b0, used_bytes} + (CapW + 1)'(sz)) > (CapW + 1)'(capacity_r) ||
                live_entries >= Entries)) begin
          drop_tail();
          ev++;
        end
        for (int i = 0; i < Entries; i++) begin
          if (cache_live[i]) cache_rank[i]++;
        end
        slot = -1;
        for (int i = 0; i < Entries; i++) begin
          if (slot < 0 && !cache_live[i]) slot = i;
        end
        if (slot >= 0) begin
          cache_live[slot]  = 1'b1;
          cache_key[slot]   = id;
          cache_bytes[slot] = sz;
          cache_rank[slot]  = 0;
          used_bytes        = used_bytes + CapW'(sz);
          live_entries++;
          r.admitted = 1'b1;
        end
      end
    end
    r.evicted = (ev > 2047) ? EvcW'(2047) : EvcW'(ev);
    r.bytes   = used_bytes;
  endtask

  // one transfer on s_axis; valid stays high into the next item unless a gap falls
  task automatic send_request(input bit act, input logic [KeyW-1:0] id,
                              input logic [SizeW-1:0] sz);
    result_t r;
    predict_access(act, id, sz, r);
    pending_results.push_back(r);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {sz, id};
    s_axis_tuser  <= act;
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  // lower valid and wait for every outstanding result
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgW-1:0] val);
    drain();
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    @(posedge clk_i);
    case (idx)
      salc_pkg::RegCapacity:  capacity_r  = val[CapW-1:0];
      salc_pkg::RegFifoMode:  fifo_r      = val[0];
      salc_pkg::RegThreshold: threshold_r = val[ThrW-1:0];
      default: ;
    endcase
  endtask

  // receiver stalls
  always @(posedge clk_i) begin
    m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // result checker
  always @(posedge clk_i) begin
    result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_results.size() == 0) begin
        report("result transfer with nothing expected");
      end else begin
        want = pending_results.pop_front();
        if (m_axis_tdata[0] !== want.hit)
          report($sformatf("hit %b, expected %b", m_axis_tdata[0], want.hit));
        if (m_axis_tdata[1] !== want.admitted)
          report($sformatf("admitted %b, expected %b", m_axis_tdata[1], want.admitted));
        if (m_axis_tdata[2] !== want.mismatch)
          report($sformatf("size_mismatch %b, expected %b", m_axis_tdata[2], want.mismatch));
        if (m_axis_tdata[13:3] !== want.evicted)
          report($sformatf("evicted_count %0d, expected %0d", m_axis_tdata[13:3],
                           want.evicted));
        if (m_axis_tdata[54:14] !== want.bytes)
          report($sformatf("bytes_used %0d, expected %0d", m_axis_tdata[54:14], want.bytes));
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("FAILURE");
      $finish;
    end
  end

  // hit, mismatch, invalidate and field extremes under reset settings and at a capacity of 2^40
  task automatic test_basic_ops();
    send_request(ActRequest, 32'h0, 32'h0);          // zero size is admitted
    send_request(ActRequest, 32'h0, 32'h0);          // hit
    send_request(ActRequest, 32'h0, 32'h5);          // size mismatch, re-admitted
    send_request(ActInvalidate, 32'h0, 32'h0);       // present
    send_request(ActInvalidate, 32'h1234, 32'h0);    // absent
    send_request(ActRequest, 32'hFFFF_FFFF, 32'hFFFF_FFFF);  // too big for 2^30
    write_reg(salc_pkg::RegCapacity, CfgW'(CapMax));
    write_reg(RegUnused, '1);                        // ignored index
    send_request(ActRequest, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_request(ActRequest, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_request(ActInvalidate, 32'hFFFF_FFFF, 32'hAAAA_5555);
  endtask

  // threshold at one and zero, capacity at zero
  task automatic test_limits();
    write_reg(salc_pkg::RegThreshold, CfgW'(1));
    send_request(ActRequest, 32'h10, 32'h0);
    send_request(ActRequest, 32'h11, 32'h1);
    write_reg(salc_pkg::RegThreshold, '0);
    send_request(ActRequest, 32'h12, 32'h0);
    write_reg(salc_pkg::RegThreshold, CfgW'(ThrMax));
    write_reg(salc_pkg::RegCapacity, '0);
    send_request(ActRequest, 32'h13, 32'h0);
    send_request(ActInvalidate, 32'h10, 32'h0);
  endtask

  // lowered capacity: hits and rejects leave the tail alone, an admission trims it
  task automatic test_capacity_lowered();
    write_reg(salc_pkg::RegCapacity, CfgW'(100));
    send_request(ActRequest, 32'h20, 32'd30);
    send_request(ActRequest, 32'h21, 32'd30);
    send_request(ActRequest, 32'h22, 32'd30);
    write_reg(salc_pkg::RegCapacity, CfgW'(40));
    send_request(ActRequest, 32'h21, 32'd30);
    send_request(ActRequest, 32'h23, 32'd50);
    send_request(ActRequest, 32'h24, 32'd10);
    send_request(ActInvalidate, 32'h24, 32'd0);
    send_request(ActInvalidate, 32'h21, 32'd0);
  endtask

  // promotion on a hit in lru mode, none in fifo mode
  task automatic test_replacement_order();
    write_reg(salc_pkg::RegCapacity, CfgW'(100));
    for (int m = 0; m < 2; m++) begin
      write_reg(salc_pkg::RegFifoMode, CfgW'(m));
      send_request(ActRequest, 32'h30, 32'd30);
      send_request(ActRequest, 32'h31, 32'd30);
      send_request(ActRequest, 32'h32, 32'd30);
      send_request(ActRequest, 32'h30, 32'd30);
      send_request(ActRequest, 32'h33, 32'd30);
      for (int k = 0; k < 4; k++) send_request(ActInvalidate, 32'h30 + k, 32'd0);
    end
    write_reg(salc_pkg::RegFifoMode, '0);
  endtask

  // fill every slot, overflow it, then flush nearly all by a capacity cut
  task automatic test_full_table();
    write_reg(salc_pkg::RegCapacity, CfgW'(salc_pkg::CapReset));
    for (int k = 0; k <= Entries; k++) send_request(ActRequest, 32'h1000 + k, 32'd1);
    write_reg(salc_pkg::RegCapacity, CfgW'(1));
    send_request(ActRequest, 32'h9000, 32'd0);
    send_request(ActRequest, 32'h9001, 32'd0);
    send_request(ActInvalidate, 32'h9000, 32'd0);
    send_request(ActInvalidate, 32'h9001, 32'd0);
    send_request(ActInvalidate, 32'h1000 + Entries, 32'd0);
  endtask

  // mostly well-formed traffic over a small key set, some noise and wide values
  task automatic test_random_traffic(input int n, input int key_span, input int max_size,
                                     input bit pause_midway);
    int r;
    logic [KeyW-1:0] id;
    logic [SizeW-1:0] sz;
    for (int k = 0; k < n; k++) begin
      r  = $urandom_range(99);
      id = $urandom_range(key_span);
      sz = (id * 13 + 7) % max_size;
      if (r < 10) begin
        send_request(ActInvalidate, id, $urandom());
      end else if (r < 15) begin
        send_request(1'($urandom_range(1)), $urandom(), $urandom());
      end else if (r < 25) begin
        send_request(ActRequest, id, $urandom_range(max_size));
      end else begin
        send_request(ActRequest, id, sz);
      end
      if (pause_midway && k == n / 2) drain();
    end
  endtask

  initial begin
    for (int i = 0; i < Entries; i++) begin
      cache_key[i]   = '0;
      cache_bytes[i] = '0;
      cache_live[i]  = 1'b0;
      cache_rank[i]  = 0;
    end
    used_bytes   = '0;
    live_entries = 0;
    capacity_r   = salc_pkg::CapReset;
    fifo_r       = 1'b0;
    threshold_r  = salc_pkg::ThrReset;

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_basic_ops();
    test_limits();
    test_capacity_lowered();
    test_replacement_order();
    test_full_table();

    write_reg(salc_pkg::RegCapacity, CfgW'(500));
    test_random_traffic(15, 40, 120, 1'b0);

    send_idle_pct = 79;
    write_reg(salc_pkg::RegFifoMode, CfgW'(1));
    write_reg(salc_pkg::RegThreshold, CfgW'(90));
    write_reg(salc_pkg::RegCapacity, CfgW'(2000));
    test_random_traffic(15, 60, 150, 1'b1);

    send_idle_pct  = 0;
    recv_stall_pct = 79;
    write_reg(salc_pkg::RegFifoMode, '0);
    write_reg(salc_pkg::RegThreshold, CfgW'(ThrMax));
    write_reg(salc_pkg::RegCapacity, CfgW'(300));
    test_random_traffic(15, 30, 100, 1'b0);

    send_idle_pct  = 26;
    recv_stall_pct = 26;
    write_reg(salc_pkg::RegFifoMode, CfgW'(1));
    write_reg(salc_pkg::RegCapacity, CfgW'(1200));
    test_random_traffic(15, 50, 130, 1'b0);

    drain();
    repeat (50) @(posedge clk_i);
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// ----- size_aware_lru_cache.f -----
rtl/salc_pkg.sv
rtl/salc_ram.sv
rtl/salc_datapath.sv
rtl/salc_ctrl.sv
rtl/size_aware_lru_cache.sv
dv/testbench.sv
